/* design/tlru_pkg.sv */
// ----------------------------------------------------------------------------
// tlru_pkg: shared types and constants for the true LRU replacement block
// Holds the fixed field widths, command codes, controller states and the
// command and status bundles that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package tlru_pkg;

    // Fixed widths of the request and result fields.
    localparam int SET_FIELD_W = 11;
    localparam int WAY_FIELD_W = 4;
    localparam int VICTIM_W    = 4;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    // Request kinds carried on tuser.
    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;   // write the reset row at the clear counter
        logic accept;     // capture the request and read its set row
        logic finish;     // the set row is evaluated: write back or emit result
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done; // the clear counter is at the last set
        logic is_query;   // the request held is a victim query
        logic out_busy;   // the output register holds a result not yet taken
    } dp_status_t;

endpackage

/* design/tlru_ram.sv */
// ----------------------------------------------------------------------------
// tlru_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while the read enable is low.
// ----------------------------------------------------------------------------
module tlru_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/tlru_dp.sv */
// ----------------------------------------------------------------------------
// tlru_dp: datapath of the true LRU replacement block
// Holds the age rows of all sets in a RAM, the clear counter, the captured
// request, the age update and victim search logic, and the output register.
// ----------------------------------------------------------------------------
module tlru_dp
    import tlru_pkg::*;
#(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int AGE_W  = $clog2(NUM_WAYS);
    localparam int ROW_W  = NUM_WAYS * AGE_W;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(NUM_WAYS - 1);

    // Request fields and range checks.
    logic [SET_FIELD_W-1:0] in_set;
    logic [WAY_FIELD_W-1:0] in_way;
    logic [16:0]            in_set_ext;
    logic [5:0]             in_way_ext;
    logic [ADDR_W-1:0]      in_addr;
    logic                   in_set_ok;
    logic                   in_way_ok;

    assign in_set     = s_tdata[SET_FIELD_W-1:0];
    assign in_way     = s_tdata[SET_FIELD_W +: WAY_FIELD_W];
    assign in_set_ext = 17'(in_set);
    assign in_way_ext = 6'(in_way);
    assign in_addr    = in_set_ext[ADDR_W-1:0];
    assign in_set_ok  = in_set_ext < 17'(NUM_SETS);
    assign in_way_ok  = in_way_ext < 6'(NUM_WAYS);

    // Captured request.
    logic              cmd_reg;
    logic              set_ok_reg;
    logic              way_ok_reg;
    logic [AGE_W-1:0]  way_reg;
    logic [ADDR_W-1:0] addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg    <= s_tuser;
            set_ok_reg <= in_set_ok;
            way_ok_reg <= in_way_ok;
            way_reg    <= in_way_ext[AGE_W-1:0];
            addr_reg   <= in_addr;
        end
    end

    // Clear counter that walks every set after reset.
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;

    assign clr_cnt_next = cmd.clear_wr ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Reset row: the age of each way equals its way number.
    logic [ROW_W-1:0] reset_row;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            reset_row[w*AGE_W +: AGE_W] = AGE_W'(w);
        end
    end

    // Age row storage.
    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  new_row;
    logic [ROW_W-1:0]  wr_row;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;

    assign wr_en   = cmd.clear_wr
                   | (cmd.finish & (cmd_reg == CMD_UPDATE) & set_ok_reg & way_ok_reg);
    assign wr_addr = cmd.clear_wr ? clr_cnt_reg : addr_reg;
    assign wr_row  = cmd.clear_wr ? reset_row : new_row;

    tlru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_row),
        .re    (cmd.accept),
        .raddr (in_addr),
        .rdata (rd_row)
    );

    // Unpack the row into ages.
    logic [AGE_W-1:0] age [NUM_WAYS];
    logic [AGE_W-1:0] pivot;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            age[w] = rd_row[w*AGE_W +: AGE_W];
        end
    end

    assign pivot = age[way_reg];

    // Age update: younger ways age by one, the touched way becomes youngest.
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (AGE_W'(w) == way_reg)
            begin
                new_row[w*AGE_W +: AGE_W] = '0;
            end
            else if (age[w] < pivot)
            begin
                new_row[w*AGE_W +: AGE_W] = age[w] + 1'b1;
            end
            else
            begin
                new_row[w*AGE_W +: AGE_W] = age[w];
            end
        end
    end

    // Victim search: the lowest-numbered way holding the oldest age, or way 0 for a set out of range.
    logic [VICTIM_W-1:0] victim;

    always_comb
    begin
        victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (age[w] == AGE_MAX)
            begin
                victim = VICTIM_W'(w);
            end
        end
        if (!set_ok_reg)
        begin
            victim = '0;
        end
    end

    // Output register.
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic [VICTIM_W-1:0] victim_reg;
    logic                load_out;

    assign load_out = cmd.finish & (cmd_reg == CMD_QUERY);

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            victim_reg <= victim;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(victim_reg);

    // Status toward the controller.
    assign status.clear_done = (clr_cnt_reg == ADDR_W'(NUM_SETS - 1));
    assign status.is_query   = (cmd_reg == CMD_QUERY);
    assign status.out_busy   = m_tvalid_reg & ~m_tready;

endmodule

/* design/tlru_ctrl.sv */
// ----------------------------------------------------------------------------
// tlru_ctrl: controller of the true LRU replacement block
// Sequences the clearing pass after reset, request acceptance and the
// evaluation state, and stalls a query while the output register is full.
// ----------------------------------------------------------------------------
module tlru_ctrl
    import tlru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // Command decode.
    always_comb
    begin
        cmd          = '0;
        s_tready     = 1'b0;
        cmd.clear_wr = (state_reg == ST_CLEAR);
        if (state_reg == ST_IDLE)
        begin
            s_tready   = 1'b1;
            cmd.accept = s_tvalid;
        end
        if (state_reg == ST_EVAL)
        begin
            cmd.finish = ~(status.is_query & status.out_busy);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (cmd.finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/true_lru_replacement.sv */
// ----------------------------------------------------------------------------
// true_lru_replacement: age-stack true LRU replacement state for a cache
// Keeps an age rank for every way of every set, updates it on hits and fills
// and answers victim queries with the least recently used way.
//
//   Channel  Dir  Payload                                   Handshake
//   s_*      in   tuser = command, tdata = set, way         tvalid/tready
//   m_*      out  tdata = victim_way                        tvalid/tready
//
// Each request first reads its set's age row from the RAM (registered read port)
// and is then evaluated: an update writes the row back, a query emits its victim.
// After reset a clearing pass writes the initial ages into every set, one set
// per cycle; s_tready stays low meanwhile.
// A request is accepted while an earlier result still waits on m_*; a query
// then stalls in evaluation until the output register is free.
// ----------------------------------------------------------------------------
module true_lru_replacement
    import tlru_pkg::*;
#(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [10:0] set_index, [14:11] way_index, [15] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] command
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [3:0] victim_way, [7:4] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Controller.
    tlru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    tlru_dp #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* verif/tb_true_lru_replacement.sv */
// ----------------------------------------------------------------------------
// tb_true_lru_replacement: self-checking bench for the true LRU replacement
// Drives victim queries and hit/fill updates into the block and keeps its own
// age table per set. Each query result is compared with the victim that the
// table predicts. A short directed table comes first, then random traffic
// that stays mostly on a few hot sets so that their age order gets deep.
// Both sides idle at random, and once the result side holds off long enough
// for the block to stall its request side.
// ----------------------------------------------------------------------------
module tb_true_lru_replacement;
    import tlru_pkg::*;

    localparam int SETS        = 2048;
    localparam int WAYS        = 16;
    localparam int RANDOM_REQS = 1400;
    localparam int HOT_SETS    = 6;
    localparam int DIR_ROWS    = 18;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 400;

    // One row of the directed table. When known is set, victim is the result
    // that can be read off directly; otherwise the age table predicts it.
    typedef struct packed {
        logic                   cmd;
        logic [SET_FIELD_W-1:0] set_idx;
        logic [WAY_FIELD_W-1:0] way_idx;
        logic                   known;
        logic [VICTIM_W-1:0]    victim;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = CMD_QUERY;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predicted age of every way of every set, and the victims still owed.
    logic [WAY_FIELD_W-1:0] lru_ages [SETS][WAYS];
    logic [VICTIM_W-1:0]    victim_queue [$];

    int unsigned mismatch_count = 0;
    int unsigned accepted_count = 0;
    int unsigned burst_left     = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // Fresh sets: the highest way is the oldest, at both ends of the index.
        '{CMD_QUERY,  11'd0,    4'd0,  1'b1, 4'd15},
        '{CMD_QUERY,  11'd2047, 4'd15, 1'b1, 4'd15},
        // Touching the oldest way hands the victim to the next one down.
        '{CMD_UPDATE, 11'd0,    4'd15, 1'b0, 4'd0},
        '{CMD_QUERY,  11'd0,    4'd15, 1'b1, 4'd14},
        '{CMD_UPDATE, 11'd0,    4'd0,  1'b0, 4'd0},
        '{CMD_QUERY,  11'd0,    4'd0,  1'b0, 4'd0},
        // Touching the youngest way changes nothing.
        '{CMD_UPDATE, 11'd2047, 4'd0,  1'b0, 4'd0},
        '{CMD_QUERY,  11'd2047, 4'd0,  1'b1, 4'd15},
        '{CMD_UPDATE, 11'd2047, 4'd15, 1'b0, 4'd0},
        '{CMD_QUERY,  11'd2047, 4'd0,  1'b1, 4'd14},
        // Alternating bit patterns in the set and way fields.
        '{CMD_UPDATE, 11'h555,  4'hA,  1'b0, 4'd0},
        '{CMD_QUERY,  11'h555,  4'h5,  1'b0, 4'd0},
        '{CMD_UPDATE, 11'h2AA,  4'h5,  1'b0, 4'd0},
        '{CMD_QUERY,  11'h2AA,  4'hA,  1'b0, 4'd0},
        // A few touches on one set, the oldest touched last.
        '{CMD_UPDATE, 11'd1,    4'd14, 1'b0, 4'd0},
        '{CMD_UPDATE, 11'd1,    4'd13, 1'b0, 4'd0},
        '{CMD_UPDATE, 11'd1,    4'd15, 1'b0, 4'd0},
        '{CMD_QUERY,  11'd1,    4'd0,  1'b0, 4'd0}
    };

    true_lru_replacement #(
        .NUM_SETS (SETS),
        .NUM_WAYS (WAYS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #600000;
        $display("Regression FAIL");
        $finish;
    end

    // The lowest-numbered way that holds the oldest age.
    function automatic logic [VICTIM_W-1:0] oldest_way(input logic [SET_FIELD_W-1:0] set_idx);
        logic [VICTIM_W-1:0] found;
        found = '0;
        for (int w = WAYS - 1; w >= 0; w--)
            if (lru_ages[set_idx][w] == WAYS - 1)
                found = VICTIM_W'(w);
        return found;
    endfunction

    // Ages every way younger than the touched one, then makes it the newest.
    task automatic touch_way(input logic [SET_FIELD_W-1:0] set_idx,
                             input logic [WAY_FIELD_W-1:0] way_idx);
        logic [WAY_FIELD_W-1:0] pivot;
        if (set_idx < SETS && way_idx < WAYS)
        begin
            pivot = lru_ages[set_idx][way_idx];
            for (int w = 0; w < WAYS; w++)
                if (lru_ages[set_idx][w] < pivot)
                    lru_ages[set_idx][w] = lru_ages[set_idx][w] + 1'b1;
            lru_ages[set_idx][way_idx] = '0;
        end
    endtask

    // Offers one request from the falling edge on and waits until it is taken.
    // A query leaves its expected victim behind; an update moves the ages.
    task automatic send_request(input logic                   cmd,
                                input logic [SET_FIELD_W-1:0] set_idx,
                                input logic [WAY_FIELD_W-1:0] way_idx,
                                input logic                   known,
                                input logic [VICTIM_W-1:0]    known_victim);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - SET_FIELD_W - WAY_FIELD_W){1'b0}}, way_idx, set_idx};
        do
            @(posedge clk);
        while (!s_tready);
        accepted_count++;
        if (cmd == CMD_QUERY)
            victim_queue.push_back(known ? known_victim : oldest_way(set_idx));
        else
            touch_way(set_idx, way_idx);
    endtask

    // Bursts of back-to-back requests with idle gaps between them.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // Result side: stall modes that change now and then, plus one long hold
    // once enough requests have gone in, so the block backs up.
    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        bit          hold_done;
        mode      = 0;
        mode_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && accepted_count >= HOLD_AFTER)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Result check against the oldest victim still owed.
    always @(posedge clk)
    begin
        logic [VICTIM_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (victim_queue.size() == 0)
            begin
                $error("victim_way: result with none expected, actual %0d",
                       m_tdata[VICTIM_W-1:0]);
                mismatch_count++;
            end
            else
            begin
                want = victim_queue.pop_front();
                if (m_tdata[VICTIM_W-1:0] !== want)
                begin
                    $error("victim_way: expected %0d, actual %0d",
                           want, m_tdata[VICTIM_W-1:0]);
                    mismatch_count++;
                end
            end
        end
    end

    // Reset, directed table, random traffic, drain and verdict.
    initial
    begin
        logic [SET_FIELD_W-1:0] hot_sets [HOT_SETS];
        logic [SET_FIELD_W-1:0] set_idx;
        logic [WAY_FIELD_W-1:0] way_idx;
        logic                   cmd;

        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++)
                lru_ages[s][w] = WAY_FIELD_W'(w);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            pace_sender();
            send_request(dir_rows[i].cmd, dir_rows[i].set_idx, dir_rows[i].way_idx,
                         dir_rows[i].known, dir_rows[i].victim);
        end

        // Most traffic stays on a few hot sets; the rest spreads over all sets.
        hot_sets[0] = '0;
        hot_sets[1] = SET_FIELD_W'(SETS - 1);
        for (int h = 2; h < HOT_SETS; h++)
            hot_sets[h] = SET_FIELD_W'($urandom_range(0, SETS - 1));

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                hot_sets[$urandom_range(2, HOT_SETS - 1)] =
                    SET_FIELD_W'($urandom_range(0, SETS - 1));
            cmd     = ($urandom_range(0, 99) < 25) ? CMD_QUERY : CMD_UPDATE;
            set_idx = ($urandom_range(0, 99) < 85) ? hot_sets[$urandom_range(0, HOT_SETS - 1)]
                                                   : SET_FIELD_W'($urandom_range(0, SETS - 1));
            way_idx = WAY_FIELD_W'($urandom_range(0, WAYS - 1));
            pace_sender();
            send_request(cmd, set_idx, way_idx, 1'b0, '0);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (victim_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
